/* src/lome_pkg.sv */
// lome_pkg: shared types and codes of the limit order matching engine
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lome_pkg;

    localparam logic [1:0] OP_ADD_BID = 2'd0;
    localparam logic [1:0] OP_ADD_ASK = 2'd1;
    localparam logic [1:0] OP_CANCEL  = 2'd2;
    localparam logic [1:0] OP_MATCH   = 2'd3;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FILL      = 3'd4;
    localparam logic [2:0] ST_MATCH_END = 3'd5;

    localparam logic [4:0] MAX_FILLS = 5'd31;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 88;

    typedef struct packed {
        logic [7:0]  comm;
        logic [15:0] tag;
        logic [7:0]  agent;
        logic [15:0] qty;
        logic [15:0] price;
    } entry_t;

    typedef struct packed {
        logic add_en;
        logic rm_en;
        logic upd_en;
        logic done_clr;
    } book_ctl_t;

endpackage

`default_nettype wire

/* src/lome_book.sv */
// lome_book: one order table kept packed in arrival order, with entry count
// and per-slot exhausted flags; depends on lome_pkg
`timescale 1ns / 1ps
`default_nettype none

module lome_book #(
    parameter int N = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lome_pkg::book_ctl_t     ctl,
    input  wire logic [$clog2(N)-1:0]    rd_idx,
    input  wire logic [$clog2(N)-1:0]    wr_idx,
    input  wire lome_pkg::entry_t        add_entry,
    input  wire logic [15:0]             upd_qty,
    output lome_pkg::entry_t             rd_entry,
    output logic                         rd_done,
    output logic [$clog2(N+1)-1:0]       cnt
);
    import lome_pkg::*;

    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N+1);

    entry_t          mem_reg [N];
    logic [N-1:0]    done_reg;
    logic [CW-1:0]   cnt_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.add_en)
        begin
            mem_reg[cnt_reg[IW-1:0]] <= add_entry;
        end
        else if (ctl.rm_en)
        begin
            for (int k = 0; k < N-1; k++)
            begin
                if (IW'(k) >= wr_idx)
                begin
                    mem_reg[k] <= mem_reg[k+1];
                end
            end
        end
        else if (ctl.upd_en)
        begin
            mem_reg[wr_idx].qty <= upd_qty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (ctl.add_en)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (ctl.rm_en)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (ctl.done_clr)
            begin
                done_reg <= '0;
            end
            else if (ctl.rm_en)
            begin
                for (int k = 0; k < N-1; k++)
                begin
                    if (IW'(k) >= wr_idx)
                    begin
                        done_reg[k] <= done_reg[k+1];
                    end
                end
                done_reg[N-1] <= 1'b0;
            end
            else if (ctl.upd_en && upd_qty == 16'd0)
            begin
                done_reg[wr_idx] <= 1'b1;
            end
        end
    end

    assign rd_entry = mem_reg[rd_idx];
    assign rd_done  = done_reg[rd_idx];
    assign cnt      = cnt_reg;

endmodule

`default_nettype wire

/* src/limit_order_matching_engine_core.sv */
// limit_order_matching_engine_core: top level with the sequencer that drives
// one shared scan/compare step over both order tables; depends on lome_pkg, lome_book
`timescale 1ns / 1ps
`default_nettype none

//  channel  | group  | tdata                                   | tuser     | tlast
//  orders   | s_axis | commodity, tag, agent, quantity, price  | operation | -
//  results  | m_axis | commodity, tags, agents, volume, price  | status    | last
//
//  cancel: searches the bid table, then the ask table
//  match: one scan of both tables per fill plus one per visited commodity, and a
//  removal sweep per commodity that has orders on both sides
//  a single scan index serves both tables
//  reset empties both tables; a stalled result stalls the sequencer only where it emits the next result
//  a new order beat is taken only when idle and the result register is empty

module limit_order_matching_engine_core #(
    parameter int ORDER_SLOTS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // commodity, order_tag, agent_id, quantity, limit_price
    input  wire logic [lome_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation
    input  wire logic [1:0]                         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // fill_commodity, bid_tag, bid_agent, ask_tag, ask_agent, fill_volume, fill_price
    output logic [lome_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // status
    output logic [2:0]                              m_axis_tuser,
    output logic                                    m_axis_tlast
);
    import lome_pkg::*;

    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS+1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADD   = 4'd1;
    localparam logic [3:0] S_CAN_B = 4'd2;
    localparam logic [3:0] S_CAN_A = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_RM_B  = 4'd6;
    localparam logic [3:0] S_RM_A  = 4'd7;
    localparam logic [3:0] S_NEXT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]              state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    entry_t                  in_reg, in_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [7:0]              c_reg, c_next;
    logic                    first_reg, first_next;
    logic                    stop_reg, stop_next;
    logic [4:0]              fills_reg, fills_next;
    logic                    bf_reg, bf_next, af_reg, af_next;
    logic [IW-1:0]           bi_reg, bi_next, ai_reg, ai_next;
    logic [15:0]             bp_reg, bp_next, ap_reg, ap_next;
    logic [15:0]             bq_reg, bq_next, aq_reg, aq_next;
    entry_t                  bb_reg, bb_next, ab_reg, ab_next;
    logic                    nv_reg, nv_next;
    logic [7:0]              nc_reg, nc_next;
    logic                    ov_reg, ov_next;
    logic [2:0]              ost_reg, ost_next;
    logic [OUT_DATA_W-1:0]   od_reg, od_next;
    logic                    ol_reg, ol_next;

    book_ctl_t               bctl, actl;
    logic [IW-1:0]           bwr, awr;
    logic [15:0]             bupd, aupd;
    entry_t                  brd, ard;
    logic                    bdone, adone;
    logic [CW-1:0]           bcnt, acnt;

    logic                    out_free;
    logic [15:0]             vol;
    logic [16:0]             psum;

    lome_book #(.N(ORDER_SLOTS)) u_bids (
        .clk(clk), .rst_n(rst_n), .ctl(bctl), .rd_idx(k_reg[IW-1:0]), .wr_idx(bwr),
        .add_entry(in_reg), .upd_qty(bupd), .rd_entry(brd), .rd_done(bdone), .cnt(bcnt)
    );

    lome_book #(.N(ORDER_SLOTS)) u_asks (
        .clk(clk), .rst_n(rst_n), .ctl(actl), .rd_idx(k_reg[IW-1:0]), .wr_idx(awr),
        .add_entry(in_reg), .upd_qty(aupd), .rd_entry(ard), .rd_done(adone), .cnt(acnt)
    );

    assign out_free      = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign vol           = (bq_reg < aq_reg) ? bq_reg : aq_reg;
    assign psum          = {1'b0, bp_reg} + {1'b0, ap_reg};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        in_next    = in_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        first_next = first_reg;
        stop_next  = stop_reg;
        fills_next = fills_reg;
        bf_next    = bf_reg;
        af_next    = af_reg;
        bi_next    = bi_reg;
        ai_next    = ai_reg;
        bp_next    = bp_reg;
        ap_next    = ap_reg;
        bq_next    = bq_reg;
        aq_next    = aq_reg;
        bb_next    = bb_reg;
        ab_next    = ab_reg;
        nv_next    = nv_reg;
        nc_next    = nc_reg;
        ov_next    = ov_reg && !m_axis_tready;
        ost_next   = ost_reg;
        od_next    = od_reg;
        ol_next    = ol_reg;
        bctl       = '0;
        actl       = '0;
        bwr        = k_reg[IW-1:0];
        awr        = k_reg[IW-1:0];
        bupd       = bq_reg - vol;
        aupd       = aq_reg - vol;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    op_next = s_axis_tuser;
                    in_next = s_axis_tdata;
                    in_next.comm  = s_axis_tdata[7:0];
                    in_next.tag   = s_axis_tdata[23:8];
                    in_next.agent = s_axis_tdata[31:24];
                    in_next.qty   = s_axis_tdata[47:32];
                    in_next.price = s_axis_tdata[63:48];
                    k_next  = '0;
                    case (s_axis_tuser)
                        OP_MATCH:
                        begin
                            c_next     = 8'd0;
                            fills_next = 5'd0;
                            stop_next  = 1'b0;
                            first_next = 1'b1;
                            bf_next    = 1'b0;
                            af_next    = 1'b0;
                            nv_next    = 1'b0;
                            bctl.done_clr = 1'b1;
                            actl.done_clr = 1'b1;
                            state_next = S_SCAN;
                        end
                        OP_CANCEL: state_next = S_CAN_B;
                        default:   state_next = S_ADD;
                    endcase
                end
            end
            S_ADD:
            begin
                ov_next  = 1'b1;
                od_next  = '0;
                ol_next  = 1'b1;
                ost_next = ST_ADDED;
                if (op_reg == OP_ADD_BID)
                begin
                    if (bcnt == CW'(ORDER_SLOTS))
                        ost_next = ST_FULL;
                    else
                        bctl.add_en = 1'b1;
                end
                else
                begin
                    if (acnt == CW'(ORDER_SLOTS))
                        ost_next = ST_FULL;
                    else
                        actl.add_en = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_CAN_B:
            begin
                if (k_reg < bcnt)
                begin
                    if (brd.comm == in_reg.comm && brd.tag == in_reg.tag)
                    begin
                        bctl.rm_en = 1'b1;
                        ov_next    = 1'b1;
                        od_next    = '0;
                        ol_next    = 1'b1;
                        ost_next   = ST_CANCELLED;
                        state_next = S_IDLE;
                    end
                    else
                        k_next = k_reg + CW'(1);
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_CAN_A;
                end
            end
            S_CAN_A:
            begin
                if (k_reg < acnt && ard.comm == in_reg.comm && ard.tag == in_reg.tag)
                begin
                    actl.rm_en = 1'b1;
                    ov_next    = 1'b1;
                    od_next    = '0;
                    ol_next    = 1'b1;
                    ost_next   = ST_CANCELLED;
                    state_next = S_IDLE;
                end
                else if (k_reg < acnt)
                    k_next = k_reg + CW'(1);
                else
                begin
                    ov_next    = 1'b1;
                    od_next    = '0;
                    ol_next    = 1'b1;
                    ost_next   = ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (k_reg < bcnt)
                begin
                    if (brd.comm == c_reg && !bdone && (!bf_reg || brd.price > bp_reg))
                    begin
                        bf_next = 1'b1;
                        bi_next = k_reg[IW-1:0];
                        bp_next = brd.price;
                        bq_next = brd.qty;
                        bb_next = brd;
                    end
                    if (brd.comm > c_reg && (!nv_next || brd.comm < nc_next))
                    begin
                        nv_next = 1'b1;
                        nc_next = brd.comm;
                    end
                end
                if (k_reg < acnt)
                begin
                    if (ard.comm == c_reg && !adone && (!af_reg || ard.price < ap_reg))
                    begin
                        af_next = 1'b1;
                        ai_next = k_reg[IW-1:0];
                        ap_next = ard.price;
                        aq_next = ard.qty;
                        ab_next = ard;
                    end
                    if (ard.comm > c_reg && (!nv_next || ard.comm < nc_next))
                    begin
                        nv_next = 1'b1;
                        nc_next = ard.comm;
                    end
                end
                if (k_reg == CW'(ORDER_SLOTS-1))
                begin
                    k_next     = '0;
                    state_next = S_EVAL;
                end
                else
                    k_next = k_reg + CW'(1);
            end
            S_EVAL:
            begin
                if (first_reg && !(bf_reg && af_reg))
                    state_next = S_NEXT;
                else if (!bf_reg || !af_reg || bp_reg < ap_reg)
                begin
                    k_next     = '0;
                    state_next = S_RM_B;
                end
                else if (fills_reg == MAX_FILLS)
                begin
                    stop_next  = 1'b1;
                    k_next     = '0;
                    state_next = S_RM_B;
                end
                else if (out_free)
                begin
                    ov_next     = 1'b1;
                    ost_next    = ST_FILL;
                    ol_next     = 1'b0;
                    od_next     = {psum[16:1], vol, ab_reg.agent, ab_reg.tag,
                                   bb_reg.agent, bb_reg.tag, c_reg};
                    bctl.upd_en = 1'b1;
                    actl.upd_en = 1'b1;
                    bwr         = bi_reg;
                    awr         = ai_reg;
                    fills_next  = fills_reg + 5'd1;
                    first_next  = 1'b0;
                    bf_next     = 1'b0;
                    af_next     = 1'b0;
                    nv_next     = 1'b0;
                    k_next      = '0;
                    state_next  = S_SCAN;
                end
            end
            S_RM_B:
            begin
                if (k_reg < bcnt)
                begin
                    if (brd.comm == c_reg && brd.qty == 16'd0)
                        bctl.rm_en = 1'b1;
                    else
                        k_next = k_reg + CW'(1);
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_RM_A;
                end
            end
            S_RM_A:
            begin
                if (k_reg < acnt)
                begin
                    if (ard.comm == c_reg && ard.qty == 16'd0)
                        actl.rm_en = 1'b1;
                    else
                        k_next = k_reg + CW'(1);
                end
                else
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (!stop_reg && nv_reg)
                begin
                    c_next        = nc_reg;
                    first_next    = 1'b1;
                    bf_next       = 1'b0;
                    af_next       = 1'b0;
                    nv_next       = 1'b0;
                    k_next        = '0;
                    bctl.done_clr = 1'b1;
                    actl.done_clr = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = ST_MATCH_END;
                    od_next    = '0;
                    ol_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            first_reg <= 1'b0;
            stop_reg  <= 1'b0;
            fills_reg <= '0;
            bf_reg    <= 1'b0;
            af_reg    <= 1'b0;
            nv_reg    <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            first_reg <= first_next;
            stop_reg  <= stop_next;
            fills_reg <= fills_next;
            bf_reg    <= bf_next;
            af_reg    <= af_next;
            nv_reg    <= nv_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        in_reg  <= in_next;
        c_reg   <= c_next;
        bi_reg  <= bi_next;
        ai_reg  <= ai_next;
        bp_reg  <= bp_next;
        ap_reg  <= ap_next;
        bq_reg  <= bq_next;
        aq_reg  <= aq_next;
        bb_reg  <= bb_next;
        ab_reg  <= ab_next;
        nc_reg  <= nc_next;
        ost_reg <= ost_next;
        od_reg  <= od_next;
        ol_reg  <= ol_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ost_reg;
    assign m_axis_tlast  = ol_reg;

endmodule

`default_nettype wire

/* src/lome_check.sv */
// lome_check: port-level checks of the matching engine core and their binding
// depends on lome_pkg and limit_order_matching_engine_core
`timescale 1ns / 1ps
`default_nettype none

module lome_check (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [2:0]                         m_axis_tuser,
    input wire logic                               m_axis_tlast
);
    import lome_pkg::*;

    // stalled result beat stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("order beat taken while busy");

    a_fill_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FILL |-> !m_axis_tlast)
        else $error("fill beat marked last");

    a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_FILL |-> m_axis_tlast)
        else $error("final beat not marked last");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("order beat offered while a result is pending");

endmodule

bind limit_order_matching_engine_core lome_check u_lome_check (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);

`default_nettype wire
